### rtl/mapf_pkg.sv
package mapf_pkg;

  // Geometry
  localparam int AXES       = 6;
  localparam int AXIS_W     = $clog2(AXES);
  localparam int COUNT_BITS = 32;

  // Field widths
  localparam int SPEED_W  = 16;
  localparam int MASK_W   = 6;
  localparam int MS_W     = 16;
  localparam int DUTY_W   = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Reset values of the configuration registers
  localparam logic [SPEED_W-1:0] SPEED_RST  = 16'd750;
  localparam logic [MASK_W-1:0]  INVERT_RST = 6'd20;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT = 1'd1;

  // Input opcodes
  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Duty saturation
  localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

endpackage

### rtl/mapf_step.sv
// Target step: trunc(speed * elapsed_ms / 1000), three-stage pipeline.
// The divide is split as (|p| >> 3) / 125, done by a reciprocal multiply
// that is exact for every dividend below 2^28.
module mapf_step (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [mapf_pkg::SPEED_W-1:0]          speed_i,
  input  logic [mapf_pkg::MS_W-1:0]             ms_i,
  output logic                                  done_o,
  output logic [mapf_pkg::COUNT_BITS-1:0]       step_o
);

  localparam int PROD_W = 33;
  localparam int N_W    = 28;
  localparam int SHIFT  = 35;
  localparam int RCP_W  = 29;
  localparam int QP_W   = N_W + RCP_W;
  localparam int Q_W    = QP_W - SHIFT;
  localparam logic [RCP_W-1:0] RECIP = RCP_W'(((64'd1 << SHIFT) + 64'd124) / 64'd125);

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [PROD_W-1:0]        mag;
  logic [N_W-1:0]           n_val;
  logic [QP_W-1:0]          qprod_q, qprod_d;
  logic                     neg_q;
  logic [Q_W-1:0]           quot;
  logic [mapf_pkg::COUNT_BITS-1:0] step_d, step_q;
  logic                     v1_q, v2_q, v3_q;

  // Stage 1: signed product, magnitude below 2^31
  assign prod_d = $signed({{(PROD_W-mapf_pkg::SPEED_W){speed_i[mapf_pkg::SPEED_W-1]}}, speed_i})
                * $signed({{(PROD_W-mapf_pkg::MS_W){1'b0}}, ms_i});

  // Stage 2: magnitude over eight, times reciprocal of 125
  assign mag     = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
  assign n_val   = mag[N_W+2:3];
  assign qprod_d = QP_W'(n_val) * QP_W'(RECIP);

  // Stage 3: quotient, sign restored (truncation toward zero)
  assign quot   = qprod_q[QP_W-1:SHIFT];
  assign step_d = neg_q ? -mapf_pkg::COUNT_BITS'(quot) : mapf_pkg::COUNT_BITS'(quot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) prod_q <= prod_d;
    if (v1_q) begin
      qprod_q <= qprod_d;
      neg_q   <= prod_q[PROD_W-1];
    end
    if (v2_q) step_q <= step_d;
  end

  assign done_o = v3_q;
  assign step_o = step_q;

endmodule

### rtl/multi_axis_encoder_p_follower.sv
// Encoder edge: accepted when idle, counter read at accept and written back
// in ST_EDGE; the next item is taken once the sequencer is back in idle.
// Control tick: product registered at accept, two more step stages, then the
// add to the target; then per axis a counter memory read, then the command
// register, which waits while the output is held. Reset clears counters
// (per-entry valid bits), target, registers to defaults.
module multi_axis_encoder_p_follower (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [mapf_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [mapf_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  // input items
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  op_i,
  input  logic [2:0]                            channel_i,
  input  logic                                  direction_level_i,
  input  logic [mapf_pkg::MS_W-1:0]             elapsed_ms_i,
  // result items
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [2:0]                            axis_o,
  output logic                                  forward_o,
  output logic                                  reverse_o,
  output logic [mapf_pkg::DUTY_W-1:0]           duty_o,
  output logic                                  last_o
);

  localparam int CW = mapf_pkg::COUNT_BITS;
  localparam int AW = mapf_pkg::AXIS_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_STEP,
    ST_RD,
    ST_OUT
  } state_e;

  state_e state_q;

  logic [mapf_pkg::SPEED_W-1:0] speed_q;
  logic [mapf_pkg::MASK_W-1:0]  invert_q;
  logic [CW-1:0]                target_q;
  logic [AW-1:0]                ch_q;
  logic                         up_q;
  logic [AW-1:0]                idx_q;

  // position counter memory
  logic [CW-1:0]                pos_mem [mapf_pkg::AXES];
  logic [mapf_pkg::AXES-1:0]    pos_vld_q;
  logic [CW-1:0]                rdata_q;
  logic                         rd_vld_q;
  logic                         mem_re, mem_we;
  logic [AW-1:0]                mem_raddr;
  logic [CW-1:0]                rd_count, mem_wdata;

  logic                         in_acc, ch_ok, step_done;
  logic [CW-1:0]                step;
  logic                         out_free;

  // command datapath
  logic [CW-1:0]                err, mag;
  logic [CW-2:0]                half;
  logic                         neg, nz;
  logic [mapf_pkg::DUTY_W-1:0]  duty_d;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign ch_ok      = (channel_i < 3'(mapf_pkg::AXES));
  assign out_free   = !out_valid_o || out_ready_i;

  // memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = idx_q;
    if (in_acc && op_i == mapf_pkg::OP_EDGE && ch_ok) begin
      mem_re    = 1'b1;
      mem_raddr = channel_i[AW-1:0];
    end else if (state_q == ST_RD) begin
      mem_re = 1'b1;
    end
  end

  assign rd_count  = rd_vld_q ? rdata_q : '0;
  assign mem_we    = (state_q == ST_EDGE);
  assign mem_wdata = up_q ? rd_count + CW'(1) : rd_count - CW'(1);

  always_ff @(posedge clk_i) begin
    if (mem_we) pos_mem[ch_q] <= mem_wdata;
    if (mem_re) rdata_q <= pos_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (mem_we) pos_vld_q[ch_q] <= 1'b1;
      if (mem_re) rd_vld_q <= pos_vld_q[mem_raddr];
    end
  end

  // target step unit
  mapf_step u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && op_i == mapf_pkg::OP_TICK),
    .speed_i (speed_q),
    .ms_i    (elapsed_ms_i),
    .done_o  (step_done),
    .step_o  (step)
  );

  // error halved toward zero, duty saturated
  assign err    = target_q - rd_count;
  assign neg    = err[CW-1];
  assign mag    = neg ? -err : err;
  assign half   = mag[CW-1:1];
  assign nz     = (half != '0);
  assign duty_d = (half > (CW-1)'(mapf_pkg::DUTY_MAX)) ? mapf_pkg::DUTY_MAX
                                                      : half[mapf_pkg::DUTY_W-1:0];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q  <= mapf_pkg::SPEED_RST;
      invert_q <= mapf_pkg::INVERT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mapf_pkg::REG_SPEED:  speed_q  <= cfg_wdata_i;
        mapf_pkg::REG_INVERT: invert_q <= cfg_wdata_i[mapf_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and command register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      target_q    <= '0;
      ch_q        <= '0;
      up_q        <= 1'b0;
      idx_q       <= '0;
      out_valid_o <= 1'b0;
      axis_o      <= '0;
      forward_o   <= 1'b0;
      reverse_o   <= 1'b0;
      duty_o      <= '0;
      last_o      <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (op_i == mapf_pkg::OP_TICK) begin
              state_q <= ST_STEP;
            end else if (ch_ok) begin
              ch_q    <= channel_i[AW-1:0];
              up_q    <= (direction_level_i == invert_q[channel_i[AW-1:0]]);
              state_q <= ST_EDGE;
            end
          end
        end
        ST_EDGE: begin
          state_q <= ST_IDLE;
        end
        ST_STEP: begin
          if (step_done) begin
            target_q <= target_q + step;
            idx_q    <= '0;
            state_q  <= ST_RD;
          end
        end
        ST_RD: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_o <= 1'b1;
            axis_o      <= 3'(idx_q);
            forward_o   <= !neg && nz;
            reverse_o   <= neg && nz;
            duty_o      <= duty_d;
            last_o      <= (idx_q == AW'(mapf_pkg::AXES - 1));
            if (idx_q == AW'(mapf_pkg::AXES - 1)) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q + AW'(1);
              state_q <= ST_RD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
